// File: rtl/kmp_pkg.sv
// kmp_pkg: shared types and codes for the KMP substring matcher.
// No dependencies; imported by kmp_ctrl and kmp_substring_matcher_top.
`default_nettype none

package kmp_pkg;

  // Character width of pattern and text bytes
  localparam int unsigned CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  // Command carried with each input beat
  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_e;

endpackage : kmp_pkg

`default_nettype wire

// File: rtl/kmp_ram.sv
// kmp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : kmp_ram

`default_nettype wire

// File: rtl/kmp_ctrl.sv
// kmp_ctrl: command sequencer and failure-link walker for the KMP matcher.
// Depends on kmp_pkg; drives the pattern and failure-table RAMs in the top level.
`default_nettype none

module kmp_ctrl #(
  parameter int unsigned PAT_MAX = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command side
  input  wire logic                         start,
  input  wire kmp_pkg::cmd_e                cmd_i,
  input  wire kmp_pkg::char_t               char_byte_i,
  input  wire logic                         last_i,
  output logic                              busy,
  // result side
  output logic                              done_o,
  output logic                              matched_o,
  // memory side
  output logic                              ram_we_o,
  output logic [$clog2(PAT_MAX)-1:0]        ram_waddr_o,
  output kmp_pkg::char_t                    ram_wchar_o,
  output logic [$clog2(PAT_MAX):0]          ram_wfail_o,
  output logic [$clog2(PAT_MAX)-1:0]        ram_raddr_o,
  input  wire kmp_pkg::char_t               ram_rchar_i,
  input  wire logic [$clog2(PAT_MAX):0]     ram_rfail_i
);

  import kmp_pkg::*;

  localparam int unsigned AW = $clog2(PAT_MAX);
  localparam int unsigned LW = AW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;       // stored pattern length
  logic            bp_neg_q, bp_neg_d; // build prefix is -1
  logic [AW-1:0]   bp_q, bp_d;         // build prefix otherwise
  logic [AW-1:0]   mp_q, mp_d;         // text match position
  logic            found_q, found_d;
  logic            pdone_q, pdone_d;   // pattern ended
  logic            text_q, text_d;     // walk is for a text beat
  logic            last_q, last_d;
  char_t           c_q, c_d;
  logic [AW-1:0]   k_q, k_d;           // walk position
  logic            done_q, done_d;
  logic            matched_q, matched_d;

  // effective pattern state after an optional restart
  logic            len_ok;
  logic [LW-1:0]   len_eff;
  logic            bp_neg_eff;
  logic [AW-1:0]   bp_eff;
  logic            found_eff;
  // walk step
  logic            hit;
  logic [LW-1:0]   res;
  logic            fnd;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    bp_neg_d   = bp_neg_q;
    bp_d       = bp_q;
    mp_d       = mp_q;
    found_d    = found_q;
    pdone_d    = pdone_q;
    text_d     = text_q;
    last_d     = last_q;
    c_d        = c_q;
    k_d        = k_q;
    done_d     = 1'b0;
    matched_d  = matched_q;

    len_eff    = pdone_q ? '0 : len_q;
    bp_neg_eff = pdone_q ? 1'b1 : bp_neg_q;
    bp_eff     = pdone_q ? '0 : bp_q;
    len_ok     = (len_eff < LW'(PAT_MAX));
    found_eff  = found_q;

    hit        = (ram_rchar_i == c_q);
    res        = '0;
    fnd        = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = len_eff[AW-1:0];
    ram_wchar_o = char_byte_i;
    ram_wfail_o = {bp_neg_eff, bp_eff};
    ram_raddr_o = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          c_d    = char_byte_i;
          last_d = last_i;
          if (cmd_i == CMD_PATTERN) begin
            // pattern beat: if the table has room, store byte and its failure entry, then extend border
            pdone_d  = last_i;
            mp_d     = '0;
            found_d  = 1'b0;
            len_d    = len_eff;
            bp_neg_d = bp_neg_eff;
            bp_d     = bp_eff;
            if (len_ok) begin
              ram_we_o = 1'b1;
              len_d    = len_eff + LW'(1);
              if (bp_neg_eff) begin
                bp_neg_d = 1'b0;
                bp_d     = '0;
              end else begin
                ram_raddr_o = bp_eff;
                k_d         = bp_eff;
                text_d      = 1'b0;
                state_d     = ST_WALK;
              end
            end
          end else begin
            // text beat: empty pattern always matches, found holds the matcher
            if (len_q == '0) begin
              found_eff = 1'b1;
            end
            if (len_q != '0 && !found_q) begin
              ram_raddr_o = mp_q;
              k_d         = mp_q;
              text_d      = 1'b1;
              state_d     = ST_WALK;
            end else if (last_i) begin
              done_d    = 1'b1;
              matched_d = found_eff;
              mp_d      = '0;
              found_d   = 1'b0;
            end else begin
              found_d = found_eff;
            end
          end
        end
      end

      ST_WALK: begin
        // one compare per cycle; a mismatch follows the failure link
        if (hit || ram_rfail_i[AW]) begin
          res     = hit ? (LW'(k_q) + LW'(1)) : '0;
          state_d = ST_IDLE;
          if (!text_q) begin
            bp_neg_d = 1'b0;
            bp_d     = res[AW-1:0];
          end else begin
            fnd = (res >= len_q);
            if (fnd) begin
              found_d = 1'b1;
              mp_d    = '0;
            end else begin
              mp_d = res[AW-1:0];
            end
            if (last_q) begin
              done_d    = 1'b1;
              matched_d = fnd;
              mp_d      = '0;
              found_d   = 1'b0;
            end
          end
        end else begin
          k_d         = ram_rfail_i[AW-1:0];
          ram_raddr_o = ram_rfail_i[AW-1:0];
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      bp_neg_q  <= 1'b1;
      bp_q      <= '0;
      mp_q      <= '0;
      found_q   <= 1'b0;
      pdone_q   <= 1'b0;
      done_q    <= 1'b0;
      text_q    <= 1'b0;
      last_q    <= 1'b0;
      c_q       <= '0;
      k_q       <= '0;
      matched_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      bp_neg_q  <= bp_neg_d;
      bp_q      <= bp_d;
      mp_q      <= mp_d;
      found_q   <= found_d;
      pdone_q   <= pdone_d;
      done_q    <= done_d;
      text_q    <= text_d;
      last_q    <= last_d;
      c_q       <= c_d;
      k_q       <= k_d;
      matched_q <= matched_d;
    end
  end

  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign matched_o = matched_q;

endmodule : kmp_ctrl

`default_nettype wire

// File: rtl/kmp_substring_matcher_top.sv
// kmp_substring_matcher_top: streaming KMP substring matcher, top level.
// Depends on kmp_pkg, kmp_ram and kmp_ctrl.
//
//  Channel   | Ports                                  | Beat taken when
//  ----------+----------------------------------------+--------------------------
//  command   | start, busy, cmd_i, char_byte_i, last_i| start && !busy
//  result    | done_o, matched_o                      | done_o (one cycle, no stall)
//
// A beat is taken while idle; a beat that needs a failure-link walk keeps busy
// high while it compares through the registered RAM read port, and over a text
// string the links followed never outnumber the bytes matched.
// The result appears the cycle after the walk ends, or after a beat with no walk.
// Reset clears the control state only; RAM contents are undefined until written.
// The receiver cannot stall: matched_o is valid only while done_o is high.
`default_nettype none

module kmp_substring_matcher_top #(
  parameter int unsigned PAT_MAX = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire kmp_pkg::cmd_e   cmd_i,
  input  wire kmp_pkg::char_t  char_byte_i,
  input  wire logic            last_i,
  output logic                 done_o,
  output logic                 matched_o
);

  import kmp_pkg::*;

  localparam int unsigned AW = $clog2(PAT_MAX);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  char_t         ram_wchar;
  logic [AW:0]   ram_wfail;
  logic [AW-1:0] ram_raddr;
  char_t         ram_rchar;
  logic [AW:0]   ram_rfail;

  // pattern bytes
  kmp_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(PAT_MAX)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wchar),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rchar)
  );

  // failure table: MSB flags -1
  kmp_ram #(
    .WIDTH(AW + 1),
    .DEPTH(PAT_MAX)
  ) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wfail),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rfail)
  );

  kmp_ctrl #(
    .PAT_MAX(PAT_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .char_byte_i (char_byte_i),
    .last_i      (last_i),
    .busy        (busy),
    .done_o      (done_o),
    .matched_o   (matched_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wchar_o (ram_wchar),
    .ram_wfail_o (ram_wfail),
    .ram_raddr_o (ram_raddr),
    .ram_rchar_i (ram_rchar),
    .ram_rfail_i (ram_rfail)
  );

  // a result follows either a walk or a text beat closing its string
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || (start && cmd_i == CMD_TEXT && last_i)))
    else $error("result without a walk or closing text beat");

  // the walker only starts on an accepted beat
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("walk started without a beat");

  // RAMs are written only on a beat, never during a walk
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!busy && start && cmd_i == CMD_PATTERN))
    else $error("RAM write outside a pattern beat");

  // a pattern beat never produces a result
  a_pat_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_PATTERN) |=> !done_o)
    else $error("result after a pattern beat");

endmodule : kmp_substring_matcher_top

`default_nettype wire
